// ===== src/lbs_pkg.sv =====
// Shared types, sizes and helper functions for the letterbox nearest-neighbour scaler.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lbs_pkg;

    localparam int MAX_SRC_DIM = 256;
    localparam int MAX_DST_DIM = 4096;

    // Raw register widths.
    localparam int SRC_REG_W = 9;
    localparam int DST_REG_W = 13;

    // Widths that hold an effective dimension and an index below it.
    localparam int SRC_DIM_W = $clog2(MAX_SRC_DIM + 1);
    localparam int DST_DIM_W = $clog2(MAX_DST_DIM + 1);
    localparam int SRC_IDX_W = $clog2(MAX_SRC_DIM);
    localparam int DST_IDX_W = $clog2(MAX_DST_DIM);

    // Frame store addressing.
    localparam int ADDR_W = 2 * SRC_IDX_W;
    localparam int PTR_W  = ADDR_W + 1;

    // Shared multiply-divide unit.
    localparam int PROD_W = DST_DIM_W + SRC_DIM_W;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DST_REG_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } in_word_t;

    typedef struct packed {
        logic [23:0] pixel_xrgb;
        logic        frame_last;
    } out_word_t;

    // One request to the shared unit: result is a * b, or (a * b) / d when divide is set.
    typedef struct packed {
        logic                 start;
        logic                 divide;
        logic [DST_DIM_W-1:0] a;
        logic [SRC_DIM_W-1:0] b;
        logic [DST_DIM_W-1:0] d;
    } lbs_op_t;

    function automatic logic [SRC_DIM_W-1:0] eff_src(input logic [SRC_REG_W-1:0] v);
        logic [SRC_DIM_W-1:0] r;
        if (v == '0)
            r = SRC_DIM_W'(1);
        else if (int'(v) > MAX_SRC_DIM)
            r = SRC_DIM_W'(MAX_SRC_DIM);
        else
            r = SRC_DIM_W'(v);
        return r;
    endfunction

    function automatic logic [DST_DIM_W-1:0] eff_dst(input logic [DST_REG_W-1:0] v);
        logic [DST_DIM_W-1:0] r;
        if (v == '0)
            r = DST_DIM_W'(1);
        else if (int'(v) > MAX_DST_DIM)
            r = DST_DIM_W'(MAX_DST_DIM);
        else
            r = DST_DIM_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/lbs_muldiv.sv =====
// Shared arithmetic unit: one multiply, optionally followed by a restoring division
// that produces one quotient bit a cycle. Depends on lbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbs_muldiv (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lbs_pkg::lbs_op_t              op,
    output logic                               done,
    output logic [lbs_pkg::PROD_W-1:0]         result
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [lbs_pkg::CNT_W-1:0]       cnt_reg;
    logic [lbs_pkg::PROD_W-1:0]      quo_reg;
    logic [lbs_pkg::DST_DIM_W-1:0]   rem_reg;
    logic [lbs_pkg::DST_DIM_W-1:0]   d_reg;

    logic [lbs_pkg::DST_DIM_W:0]     trial;
    logic [lbs_pkg::DST_DIM_W:0]     diff;
    logic                            fits;

    // The dividend shifts out of the top of quo_reg while quotient bits enter at the bottom.
    assign trial = {rem_reg, quo_reg[lbs_pkg::PROD_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = (trial >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            d_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (op.start)
            begin
                quo_reg <= op.a * op.b;
                rem_reg <= '0;
                d_reg   <= op.d;
                if (op.divide)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= lbs_pkg::CNT_W'(lbs_pkg::PROD_W);
                end
                else
                begin
                    done_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[lbs_pkg::PROD_W-2:0], fits};
                rem_reg <= fits ? diff[lbs_pkg::DST_DIM_W-1:0] : trial[lbs_pkg::DST_DIM_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == lbs_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = quo_reg;

    a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        op.start |-> !busy_reg)
        else $error("shared unit started while a division is running");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && busy_reg))
        else $error("shared unit flags done while still iterating");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < d_reg))
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// ===== src/lbs_frame_store.sv =====
// Source frame store: one write port and one read port with registered read data.
// Depends on lbs_pkg for its address width.
`timescale 1ns / 1ps
`default_nettype none

module lbs_frame_store (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [lbs_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [23:0]                wr_data,
    input  wire logic                       rd_en,
    input  wire logic [lbs_pkg::ADDR_W-1:0] rd_addr,
    output logic [23:0]                     rd_data
);

    logic [23:0] mem [2**lbs_pkg::ADDR_W];
    logic [23:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/letterbox_nearest_scaler.sv =====
// Top level of the letterbox nearest-neighbour scaler: sequencer, geometry and raster state.
// Depends on lbs_pkg, lbs_muldiv and lbs_frame_store.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one command word at a time. A load word writes the next source pixel
// into the frame store. A request word returns one XRGB pixel of the target frame in
// raster order, with frame_last set on the final pixel. A border pixel needs no
// division; for a pixel inside the scaled picture the source column and row each come
// from a 22-step division on the single shared multiply-divide unit, followed by one
// multiply for the store address. The first request after reset, after any register write
// or at the start of a new frame also recomputes the scale and centring, which is two
// multiplies and two further divisions on the same unit.
// cmd_stall stays high while a word is being worked on; a finished pixel waits in the
// output register, so the next command can be taken while it is still unread. The frame
// store is not cleared: request pixels only after the whole source image has been loaded.
// Register writes are accepted while no command is in progress.
module letterbox_nearest_scaler (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Command channel
    input  wire logic                           cmd_valid,
    output logic                                cmd_stall,
    input  wire lbs_pkg::in_word_t              cmd_word,
    // Pixel channel
    output logic                                pix_valid,
    input  wire logic                           pix_stall,
    output lbs_pkg::out_word_t                  pix_word,
    // Configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lbs_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LMUL,
        S_GM1,
        S_GM2,
        S_GD1,
        S_GD2,
        S_CHK,
        S_DX,
        S_DY,
        S_ADR,
        S_OUT
    } state_t;

    state_t                           state_reg;

    // Configuration registers, raw bits.
    logic [lbs_pkg::SRC_REG_W-1:0]    src_w_reg;
    logic [lbs_pkg::SRC_REG_W-1:0]    src_h_reg;
    logic [lbs_pkg::DST_REG_W-1:0]    dst_w_reg;
    logic [lbs_pkg::DST_REG_W-1:0]    dst_h_reg;

    // Geometry, recomputed on the first request after reset, a register write or a frame end.
    logic                             dirty_reg;
    logic [lbs_pkg::PROD_W-1:0]       tmp_reg;
    logic [lbs_pkg::DST_DIM_W-1:0]    num_reg;
    logic [lbs_pkg::SRC_DIM_W-1:0]    den_reg;
    logic [lbs_pkg::DST_DIM_W-1:0]    ext_w_reg;
    logic [lbs_pkg::DST_DIM_W-1:0]    ext_h_reg;
    logic [lbs_pkg::DST_IDX_W-1:0]    offx_reg;
    logic [lbs_pkg::DST_IDX_W-1:0]    offy_reg;

    // Raster and load state.
    logic [lbs_pkg::PTR_W-1:0]        load_ptr_reg;
    logic [lbs_pkg::DST_IDX_W-1:0]    col_reg;
    logic [lbs_pkg::DST_IDX_W-1:0]    row_reg;

    // Per-word working registers.
    lbs_pkg::in_word_t                word_reg;
    logic                             inside_reg;
    logic [lbs_pkg::SRC_IDX_W-1:0]    sx_reg;

    lbs_pkg::lbs_op_t                 op_reg;
    logic                             pix_valid_reg;
    lbs_pkg::out_word_t               pix_word_reg;

    // Effective sizes and combinational helpers.
    logic [lbs_pkg::SRC_DIM_W-1:0]    sw;
    logic [lbs_pkg::SRC_DIM_W-1:0]    sh;
    logic [lbs_pkg::DST_DIM_W-1:0]    dw;
    logic [lbs_pkg::DST_DIM_W-1:0]    dh;

    logic                             unit_done;
    logic [lbs_pkg::PROD_W-1:0]       unit_res;

    logic                             width_bound;
    logic [lbs_pkg::DST_DIM_W-1:0]    num_sel;
    logic [lbs_pkg::SRC_DIM_W-1:0]    den_sel;
    logic [lbs_pkg::DST_DIM_W-1:0]    ext_h_new;
    logic [lbs_pkg::DST_IDX_W-1:0]    dx;
    logic [lbs_pkg::DST_IDX_W-1:0]    dy;
    logic                             in_pic;
    logic [lbs_pkg::SRC_IDX_W-1:0]    sy;
    logic                             col_last;
    logic                             row_last;
    logic                             out_free;

    logic                             wr_en;
    logic                             rd_en;
    logic [lbs_pkg::ADDR_W-1:0]       rd_addr;
    logic [23:0]                      rd_data;

    function automatic lbs_pkg::lbs_op_t make_op(
        input logic                          divide,
        input logic [lbs_pkg::DST_DIM_W-1:0] a,
        input logic [lbs_pkg::SRC_DIM_W-1:0] b,
        input logic [lbs_pkg::DST_DIM_W-1:0] d
    );
        lbs_pkg::lbs_op_t o;
        o.start  = 1'b1;
        o.divide = divide;
        o.a      = a;
        o.b      = b;
        o.d      = d;
        return o;
    endfunction

    // Quotients of the extent divisions cannot exceed the target size for a well-formed
    // ratio, but the clamp keeps the border arithmetic safe.
    function automatic logic [lbs_pkg::DST_DIM_W-1:0] clamp_ext(
        input logic [lbs_pkg::PROD_W-1:0]    q,
        input logic [lbs_pkg::DST_DIM_W-1:0] lim
    );
        logic [lbs_pkg::DST_DIM_W-1:0] r;
        if (q > lbs_pkg::PROD_W'(lim))
            r = lim;
        else
            r = q[lbs_pkg::DST_DIM_W-1:0];
        return r;
    endfunction

    // A source coordinate past the last column or row sticks to the edge.
    function automatic logic [lbs_pkg::SRC_IDX_W-1:0] clamp_src(
        input logic [lbs_pkg::PROD_W-1:0]    q,
        input logic [lbs_pkg::SRC_DIM_W-1:0] lim
    );
        logic [lbs_pkg::SRC_IDX_W-1:0] r;
        if (q >= lbs_pkg::PROD_W'(lim))
            r = lbs_pkg::SRC_IDX_W'(lim - 1'b1);
        else
            r = q[lbs_pkg::SRC_IDX_W-1:0];
        return r;
    endfunction

    assign sw = lbs_pkg::eff_src(src_w_reg);
    assign sh = lbs_pkg::eff_src(src_h_reg);
    assign dw = lbs_pkg::eff_dst(dst_w_reg);
    assign dh = lbs_pkg::eff_dst(dst_h_reg);

    // The scale is dw/sw when dw*sh <= dh*sw, otherwise dh/sh. tmp_reg holds dw*sh while
    // the unit result holds dh*sw.
    assign width_bound = (tmp_reg <= unit_res);
    assign num_sel     = width_bound ? dw : dh;
    assign den_sel     = width_bound ? sw : sh;
    assign ext_h_new   = clamp_ext(unit_res, dh);

    assign dx     = col_reg - offx_reg;
    assign dy     = row_reg - offy_reg;
    assign in_pic = (col_reg >= offx_reg) && (lbs_pkg::DST_DIM_W'(dx) < ext_w_reg) &&
                    (row_reg >= offy_reg) && (lbs_pkg::DST_DIM_W'(dy) < ext_h_reg);
    assign sy     = clamp_src(unit_res, sh);

    assign col_last = ((lbs_pkg::DST_DIM_W'(col_reg) + 1'b1) >= dw);
    assign row_last = ((lbs_pkg::DST_DIM_W'(row_reg) + 1'b1) >= dh);
    assign out_free = !pix_valid_reg || !pix_stall;

    // Loads past the source pixel count are dropped.
    assign wr_en   = (state_reg == S_LMUL) && unit_done &&
                     (lbs_pkg::PROD_W'(load_ptr_reg) < unit_res);
    assign rd_en   = (state_reg == S_ADR) && unit_done;
    assign rd_addr = unit_res[lbs_pkg::ADDR_W-1:0] + lbs_pkg::ADDR_W'(sx_reg);

    lbs_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op_reg),
        .done   (unit_done),
        .result (unit_res)
    );

    lbs_frame_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (load_ptr_reg[lbs_pkg::ADDR_W-1:0]),
        .wr_data ({word_reg.red, word_reg.green, word_reg.blue}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_w_reg     <= lbs_pkg::SRC_REG_W'(1);
            src_h_reg     <= lbs_pkg::SRC_REG_W'(1);
            dst_w_reg     <= lbs_pkg::DST_REG_W'(1);
            dst_h_reg     <= lbs_pkg::DST_REG_W'(1);
            dirty_reg     <= 1'b1;
            tmp_reg       <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            ext_w_reg     <= '0;
            ext_h_reg     <= '0;
            offx_reg      <= '0;
            offy_reg      <= '0;
            load_ptr_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            word_reg      <= '0;
            inside_reg    <= 1'b0;
            sx_reg        <= '0;
            op_reg        <= '0;
            pix_valid_reg <= 1'b0;
            pix_word_reg  <= '0;
        end
        else
        begin
            op_reg.start <= 1'b0;

            if (pix_valid_reg && !pix_stall)
                pix_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    lbs_pkg::CFG_SRC_WIDTH:
                    begin
                        src_w_reg <= cfg_data[lbs_pkg::SRC_REG_W-1:0];
                        dirty_reg <= 1'b1;
                    end
                    lbs_pkg::CFG_SRC_HEIGHT:
                    begin
                        src_h_reg <= cfg_data[lbs_pkg::SRC_REG_W-1:0];
                        dirty_reg <= 1'b1;
                    end
                    lbs_pkg::CFG_DST_WIDTH:
                    begin
                        dst_w_reg <= cfg_data;
                        dirty_reg <= 1'b1;
                    end
                    lbs_pkg::CFG_DST_HEIGHT:
                    begin
                        dst_h_reg <= cfg_data;
                        dirty_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        word_reg <= cmd_word;
                        if (cmd_word.cmd == lbs_pkg::CMD_EMIT)
                        begin
                            if (dirty_reg)
                            begin
                                op_reg    <= make_op(1'b0, dw, sh, dw);
                                state_reg <= S_GM1;
                            end
                            else
                            begin
                                state_reg <= S_CHK;
                            end
                        end
                        else
                        begin
                            // The pixel count sw*sh bounds the load pointer.
                            op_reg    <= make_op(1'b0, lbs_pkg::DST_DIM_W'(sw), sh, dw);
                            state_reg <= S_LMUL;
                        end
                    end
                end

                S_LMUL:
                begin
                    if (unit_done)
                    begin
                        if (wr_en)
                            load_ptr_reg <= load_ptr_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end

                S_GM1:
                begin
                    if (unit_done)
                    begin
                        tmp_reg   <= unit_res;
                        op_reg    <= make_op(1'b0, dh, sw, dw);
                        state_reg <= S_GM2;
                    end
                end

                S_GM2:
                begin
                    if (unit_done)
                    begin
                        num_reg   <= num_sel;
                        den_reg   <= den_sel;
                        op_reg    <= make_op(1'b1, num_sel, sw,
                                             lbs_pkg::DST_DIM_W'(den_sel));
                        state_reg <= S_GD1;
                    end
                end

                S_GD1:
                begin
                    if (unit_done)
                    begin
                        ext_w_reg <= clamp_ext(unit_res, dw);
                        op_reg    <= make_op(1'b1, num_reg, sh,
                                             lbs_pkg::DST_DIM_W'(den_reg));
                        state_reg <= S_GD2;
                    end
                end

                S_GD2:
                begin
                    if (unit_done)
                    begin
                        ext_h_reg <= ext_h_new;
                        offx_reg  <= lbs_pkg::DST_IDX_W'((dw - ext_w_reg) >> 1);
                        offy_reg  <= lbs_pkg::DST_IDX_W'((dh - ext_h_new) >> 1);
                        dirty_reg <= 1'b0;
                        state_reg <= S_CHK;
                    end
                end

                S_CHK:
                begin
                    inside_reg <= in_pic;
                    if (in_pic)
                    begin
                        op_reg    <= make_op(1'b1, lbs_pkg::DST_DIM_W'(dx), den_reg, num_reg);
                        state_reg <= S_DX;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end

                S_DX:
                begin
                    if (unit_done)
                    begin
                        sx_reg    <= clamp_src(unit_res, sw);
                        op_reg    <= make_op(1'b1, lbs_pkg::DST_DIM_W'(dy), den_reg, num_reg);
                        state_reg <= S_DY;
                    end
                end

                S_DY:
                begin
                    if (unit_done)
                    begin
                        // Linear store address sy * sw, sx is added on the read.
                        op_reg    <= make_op(1'b0, lbs_pkg::DST_DIM_W'(sy), sw, dw);
                        state_reg <= S_ADR;
                    end
                end

                S_ADR:
                begin
                    if (unit_done)
                        state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        pix_valid_reg           <= 1'b1;
                        pix_word_reg.pixel_xrgb <= inside_reg ? rd_data : 24'd0;
                        pix_word_reg.frame_last <= col_last && row_last;
                        if (col_last)
                        begin
                            col_reg <= '0;
                            if (row_last)
                            begin
                                row_reg      <= '0;
                                load_ptr_reg <= '0;
                                // The next frame starts with fresh geometry.
                                dirty_reg    <= 1'b1;
                            end
                            else
                            begin
                                row_reg <= row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign pix_valid = pix_valid_reg;
    assign pix_word  = pix_word_reg;

    a_ptr_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        load_ptr_reg <= lbs_pkg::PTR_W'(lbs_pkg::MAX_SRC_DIM * lbs_pkg::MAX_SRC_DIM))
        else $error("load pointer ran past the frame store");

    a_last_restarts_raster: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid_reg && pix_word_reg.frame_last) |-> (col_reg == '0 && row_reg == '0))
        else $error("frame_last shown while the raster has not wrapped");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        unit_done |-> (state_reg == S_LMUL || state_reg == S_GM1 || state_reg == S_GM2 ||
                       state_reg == S_GD1 || state_reg == S_GD2 || state_reg == S_DX ||
                       state_reg == S_DY || state_reg == S_ADR))
        else $error("shared unit finished while the sequencer was not waiting for it");

endmodule

`default_nettype wire
